### src/c26c_pkg.sv
// shared constants, types and octant geometry for the 26-connected component counter
`default_nettype none

package c26c_pkg;

  localparam int VOXELS  = 27;
  localparam int OCTANTS = 8;
  localparam int CENTRE  = 13;
  localparam int MASK_W  = 27;
  localparam int COUNT_W = 4;
  localparam int VOX_IDX_W = $clog2(VOXELS);

  typedef struct packed {
    logic [OCTANTS-1:0][OCTANTS-1:0] reach;
    logic [OCTANTS-1:0]              active;
  } graph_t;

  // octants that contain the voxel at (x, y, z)
  function automatic logic [OCTANTS-1:0] octant_set(input int x, input int y, input int z);
    logic [OCTANTS-1:0] s;
    int ox;
    int oy;
    int oz;
    s = '0;
    for (int o = 0; o < OCTANTS; o++) begin
      ox = o & 1;
      oy = (o >> 1) & 1;
      oz = (o >> 2) & 1;
      if (x >= ox && x <= ox + 1 && y >= oy && y <= oy + 1 && z >= oz && z <= oz + 1) begin
        s[o] = 1'b1;
      end
    end
    return s;
  endfunction

  // a corner voxel lies in one octant only
  function automatic logic is_corner(input int x, input int y, input int z);
    return (x != 1) && (y != 1) && (z != 1);
  endfunction

endpackage

`default_nettype wire

### src/c26c_adj.sv
// first stage: octant adjacency and occupancy from the voxel mask
`default_nettype none

module c26c_adj (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [c26c_pkg::MASK_W-1:0]  mask,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output c26c_pkg::graph_t                  graph
);

  c26c_pkg::graph_t              graph_next;
  logic [c26c_pkg::OCTANTS-1:0]  oset;
  int                            k;

  always_comb begin
    graph_next = '0;
    oset = '0;
    k = 0;
    for (int o = 0; o < c26c_pkg::OCTANTS; o++) begin
      graph_next.reach[o][o] = 1'b1;
    end
    for (int z = 0; z < 3; z++) begin
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          k = 9 * z + 3 * y + x;
          oset = c26c_pkg::octant_set(x, y, z);
          if (k != c26c_pkg::CENTRE && mask[c26c_pkg::VOX_IDX_W'(k)]) begin
            graph_next.active = graph_next.active | oset;
            if (!c26c_pkg::is_corner(x, y, z)) begin
              for (int i = 0; i < c26c_pkg::OCTANTS; i++) begin
                if (oset[i]) begin
                  graph_next.reach[i] = graph_next.reach[i] | oset;
                end
              end
            end
          end
        end
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      graph <= graph_next;
    end
  end

endmodule

`default_nettype wire

### src/c26c_close.sv
// one boolean squaring step of the octant reachability matrix
`default_nettype none

module c26c_close (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire c26c_pkg::graph_t in_graph,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output c26c_pkg::graph_t      out_graph
);

  c26c_pkg::graph_t graph_next;

  always_comb begin
    graph_next.active = in_graph.active;
    graph_next.reach = '0;
    for (int i = 0; i < c26c_pkg::OCTANTS; i++) begin
      for (int j = 0; j < c26c_pkg::OCTANTS; j++) begin
        for (int m = 0; m < c26c_pkg::OCTANTS; m++) begin
          graph_next.reach[i][j] = graph_next.reach[i][j]
                                 | (in_graph.reach[i][m] & in_graph.reach[m][j]);
        end
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_graph <= graph_next;
    end
  end

endmodule

`default_nettype wire

### src/c26c_count.sv
// last stage: count class representatives and hold the result
`default_nettype none

module c26c_count (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire c26c_pkg::graph_t              in_graph,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [c26c_pkg::COUNT_W-1:0]       count
);

  logic [c26c_pkg::OCTANTS-1:0] root;
  logic [c26c_pkg::COUNT_W-1:0] count_next;

  // an active octant is a root when no lower octant is reachable from it
  always_comb begin
    root = '0;
    count_next = '0;
    for (int o = 0; o < c26c_pkg::OCTANTS; o++) begin
      root[o] = in_graph.active[o];
      for (int j = 0; j < o; j++) begin
        if (in_graph.reach[o][j]) begin
          root[o] = 1'b0;
        end
      end
      count_next = count_next + c26c_pkg::COUNT_W'(root[o]);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

### src/count_26_components_3x3x3.sv
// top level of the 26-connected object component counter for a 3x3x3 neighbourhood
//
// Accepts one 27-bit neighbourhood mask per cycle while the output side does
// not stall and returns the number of 26-connected object components among
// the 26 non-centre voxels. The five register stages are: octant adjacency
// from the mask, three boolean squarings of the 8x8 octant reachability
// matrix (paths of up to eight steps), and the count of class
// representatives. Each stage holds its own valid bit, so a stall at the
// output backs up through the stages without losing or repeating items.
`default_nettype none

module count_26_components_3x3x3 (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          mask_valid,
  output logic                               mask_ready,
  input  wire logic [c26c_pkg::MASK_W-1:0]   neighbour_mask,
  output logic                               count_valid,
  input  wire logic                          count_ready,
  output logic [c26c_pkg::COUNT_W-1:0]       component_count
);

  c26c_pkg::graph_t g0;
  c26c_pkg::graph_t g1;
  c26c_pkg::graph_t g2;
  c26c_pkg::graph_t g3;
  logic v0;
  logic v1;
  logic v2;
  logic v3;
  logic r1;
  logic r2;
  logic r3;
  logic r4;

  c26c_adj u_adj (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mask_valid),
    .in_ready  (mask_ready),
    .mask      (neighbour_mask),
    .out_valid (v0),
    .out_ready (r1),
    .graph     (g0)
  );

  c26c_close u_close0 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .in_ready  (r1),
    .in_graph  (g0),
    .out_valid (v1),
    .out_ready (r2),
    .out_graph (g1)
  );

  c26c_close u_close1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (r2),
    .in_graph  (g1),
    .out_valid (v2),
    .out_ready (r3),
    .out_graph (g2)
  );

  c26c_close u_close2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (r3),
    .in_graph  (g2),
    .out_valid (v3),
    .out_ready (r4),
    .out_graph (g3)
  );

  c26c_count u_count (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_ready  (r4),
    .in_graph  (g3),
    .out_valid (count_valid),
    .out_ready (count_ready),
    .count     (component_count)
  );

endmodule

`default_nettype wire

### src/c26c_checker.sv
// port-level checks for the component counter and the bind that attaches them
`default_nettype none

module c26c_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          mask_valid,
  input wire logic                          mask_ready,
  input wire logic [c26c_pkg::MASK_W-1:0]   neighbour_mask,
  input wire logic                          count_valid,
  input wire logic                          count_ready,
  input wire logic [c26c_pkg::COUNT_W-1:0]  component_count
);

  // result held while stalled
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    count_valid && !count_ready |=> count_valid)
    else $error("result dropped while stalled");

  a_hold_count: assert property (@(posedge clk) disable iff (rst)
    count_valid && !count_ready |=> $stable(component_count))
    else $error("result changed while stalled");

  // at most eight octant classes
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count_valid |-> component_count <= c26c_pkg::COUNT_W'(c26c_pkg::OCTANTS))
    else $error("component count out of range");

  // an empty or draining output leaves room for a new transfer
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    (!count_valid || count_ready) |-> mask_ready)
    else $error("input stalled with room in the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !count_valid)
    else $error("result valid after reset");

endmodule

bind count_26_components_3x3x3 c26c_checker u_checker (.*);

`default_nettype wire

### verif/count_components_checker.sv
// checker for the 26-connected component counter: watches both channels, predicts and compares
`default_nettype none

module count_components_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        mask_valid,
  input  wire logic                        mask_ready,
  input  wire logic [c26c_pkg::MASK_W-1:0]  neighbour_mask,
  input  wire logic                        count_valid,
  input  wire logic                        count_ready,
  input  wire logic [c26c_pkg::COUNT_W-1:0] component_count,
  output int                               error_count,
  output int                               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MID_VOXEL = 13;

  typedef struct {
    logic [c26c_pkg::MASK_W-1:0]  mask;
    logic [c26c_pkg::COUNT_W-1:0] parts;
  } count_entry_t;

  count_entry_t pending_counts[$];
  int           fails = 0;

  // octant labelling: shared voxels merge classes, corner voxels mark one octant
  function automatic logic [c26c_pkg::COUNT_W-1:0] count_object_parts(
    input logic [c26c_pkg::MASK_W-1:0] m
  );
    int         root[8];
    logic [7:0] touched;
    logic [7:0] corner_hit;
    logic [7:0] members;
    int         x, y, z, ox, oy, oz;
    int         lowest, old_root;
    logic [c26c_pkg::COUNT_W-1:0] n;
    touched    = '0;
    corner_hit = '0;
    for (int o = 0; o < 8; o++) begin
      root[o] = o;
    end
    for (int k = 0; k < 27; k++) begin
      if (k != MID_VOXEL && m[k]) begin
        x = k % 3;
        y = (k / 3) % 3;
        z = k / 9;
        members = '0;
        for (int o = 0; o < 8; o++) begin
          ox = o & 1;
          oy = (o >> 1) & 1;
          oz = (o >> 2) & 1;
          if (x >= ox && x <= ox + 1 && y >= oy && y <= oy + 1 && z >= oz && z <= oz + 1) begin
            members[o] = 1'b1;
          end
        end
        if ($countones(members) == 1) begin
          corner_hit = corner_hit | members;
        end else begin
          lowest = 8;
          for (int o = 0; o < 8; o++) begin
            if (members[o] && root[o] < lowest) begin
              lowest = root[o];
            end
          end
          for (int o = 0; o < 8; o++) begin
            if (members[o]) begin
              touched[o] = 1'b1;
              if (root[o] != lowest) begin
                old_root = root[o];
                for (int j = 0; j < 8; j++) begin
                  if (root[j] == old_root) begin
                    root[j] = lowest;
                  end
                end
              end
            end
          end
        end
      end
    end
    n = '0;
    for (int o = 0; o < 8; o++) begin
      if (root[o] == o && (touched[o] || corner_hit[o])) begin
        n = n + 1'b1;
      end
    end
    return n;
  endfunction

  always @(posedge clk) begin : watch
    count_entry_t head;
    if (rst) begin
      pending_counts.delete();
      fails = 0;
    end else begin
      if (count_valid && count_ready) begin
        if (pending_counts.size() == 0) begin
          if (fails < 10) begin
            $display("unexpected count transfer: got %0d", component_count);
          end
          fails++;
        end else begin
          head = pending_counts.pop_front();
          if (component_count !== head.parts) begin
            if (fails < 10) begin
              $display("component_count mismatch: mask %h expected %0d actual %0d",
                       head.mask, head.parts, component_count);
            end
            fails++;
          end
        end
      end
      if (mask_valid && mask_ready) begin
        head.mask  = neighbour_mask;
        head.parts = count_object_parts(neighbour_mask);
        pending_counts.push_back(head);
      end
    end
    error_count <= fails;
    outstanding <= pending_counts.size();
  end

endmodule

`default_nettype wire

### verif/tb_count_26_components_3x3x3.sv
// testbench top for the 26-connected component counter: stimulus, stalls and verdict
`default_nettype none

module tb_count_26_components_3x3x3;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 930;
  localparam int HOLD_AFTER   = 350;
  localparam int HOLD_CYCLES  = 200;

  localparam logic [c26c_pkg::MASK_W-1:0] ALL_VOXELS  = 27'h7FFFFFF;
  localparam logic [c26c_pkg::MASK_W-1:0] CORNER_SET  = 27'h5140145;
  localparam logic [c26c_pkg::MASK_W-1:0] EDGE_SET    = 27'h2AA8AAA;
  localparam logic [c26c_pkg::MASK_W-1:0] FACE_SET    = 27'h0415410;
  localparam logic [c26c_pkg::MASK_W-1:0] MID_BIT     = 27'h0002000;

  logic clk = 1'b0;
  logic rst;
  logic mask_valid;
  logic mask_ready;
  logic [c26c_pkg::MASK_W-1:0] neighbour_mask;
  logic count_valid;
  logic count_ready;
  logic [c26c_pkg::COUNT_W-1:0] component_count;

  int error_count;
  int outstanding;
  int sent_count;
  int cycle_count;
  logic quiet;

  always #4 clk = ~clk;

  count_26_components_3x3x3 i_dut (
    .clk            (clk),
    .rst            (rst),
    .mask_valid     (mask_valid),
    .mask_ready     (mask_ready),
    .neighbour_mask (neighbour_mask),
    .count_valid    (count_valid),
    .count_ready    (count_ready),
    .component_count(component_count)
  );

  count_components_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .mask_valid     (mask_valid),
    .mask_ready     (mask_ready),
    .neighbour_mask (neighbour_mask),
    .count_valid    (count_valid),
    .count_ready    (count_ready),
    .component_count(component_count),
    .error_count    (error_count),
    .outstanding    (outstanding)
  );

  task automatic send_mask(input logic [c26c_pkg::MASK_W-1:0] m);
    while (!quiet && $urandom_range(0, 99) < 30) begin
      mask_valid <= 1'b0;
      @(posedge clk);
    end
    mask_valid     <= 1'b1;
    neighbour_mask <= m;
    @(posedge clk);
    while (!mask_ready) begin
      @(posedge clk);
    end
    sent_count <= sent_count + 1;
  endtask

  task automatic wait_drained();
    mask_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [c26c_pkg::MASK_W-1:0] sparse_mask(input int density);
    logic [c26c_pkg::MASK_W-1:0] m;
    for (int k = 0; k < c26c_pkg::MASK_W; k++) begin
      m[k] = ($urandom_range(0, 15) < density);
    end
    return m;
  endfunction

  function automatic logic [c26c_pkg::MASK_W-1:0] random_mask();
    logic [c26c_pkg::MASK_W-1:0] m;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      m = c26c_pkg::MASK_W'($urandom());
    end else if (kind < 7) begin
      m = sparse_mask($urandom_range(1, 12));
    end else if (kind < 9) begin
      m = (CORNER_SET & c26c_pkg::MASK_W'($urandom())) | sparse_mask($urandom_range(1, 3));
    end else begin
      m = c26c_pkg::MASK_W'($urandom() & $urandom() & $urandom());
    end
    return m;
  endfunction

  // stimulus
  initial begin
    rst            <= 1'b1;
    mask_valid     <= 1'b0;
    neighbour_mask <= '0;
    sent_count     <= 0;
    quiet          <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_mask('0);
    send_mask(ALL_VOXELS);
    send_mask(MID_BIT);
    send_mask(ALL_VOXELS & ~MID_BIT);
    send_mask(CORNER_SET);
    send_mask(CORNER_SET | MID_BIT);
    send_mask(27'h0000001);
    send_mask(27'h4000000);
    send_mask(27'h4000001);
    send_mask(27'h0000010);
    send_mask(27'h0000002);
    send_mask(CORNER_SET | 27'h0000002);
    send_mask(EDGE_SET);
    send_mask(FACE_SET);
    send_mask(FACE_SET | MID_BIT);
    send_mask(EDGE_SET | CORNER_SET);
    send_mask(27'h5555555);
    send_mask(27'h2AAAAAA);
    send_mask(27'h0002001);
    send_mask(27'h4002000 | CORNER_SET);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet <= (i >= 500 && i < 700);
      if (i == 250) begin
        wait_drained();
      end
      send_mask(random_mask());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: random stalls plus one long hold-off
  initial begin : receiver
    int   hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    count_ready <= 1'b0;
    @(posedge clk);
    while (rst) begin
      @(posedge clk);
    end
    forever begin
      if (!hold_done && sent_count >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        count_ready <= 1'b0;
        hold_left--;
      end else begin
        count_ready <= quiet || ($urandom_range(0, 99) >= 30);
      end
      @(posedge clk);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
